@@ hdl/rei_pkg.sv @@
// Shared types, constants and helpers for the range encoder interval stage.
// No dependencies.
package rei_pkg;

	localparam int WORD_W = 16;

	localparam logic [15:0] RANGE_RESET = 16'h8000;
	localparam logic signed [5:0] COUNT_RESET = -6'sd9;
	localparam logic [15:0] Q15_TOTAL = 16'd32768;
	localparam logic [15:0] MIN_TOTAL = 16'd16384;
	localparam logic [15:0] PRE_MIN_TOTAL = 16'd2;

	// result buffer between the coding step and the output channel
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic last;
		logic bad;
	} res_t;

	// number of significant bits, 0 for zero
	function automatic logic [4:0] bitlen16(input logic [15:0] x);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) begin
				n = 5'(i + 1);
			end
		end
		return n;
	endfunction

	// piecewise-linear frequency map: x + min(x, g) + min((x - g)+ / 2, d)
	function automatic logic [18:0] map_freq(input logic [16:0] x, input logic [16:0] g,
		input logic [15:0] d);
		logic [16:0] m1;
		logic [16:0] t;
		logic [15:0] h;
		logic [15:0] m2;
		m1 = (x < g) ? x : g;
		t = (x > g) ? (x - g) : 17'd0;
		h = t[16:1];
		m2 = (h < d) ? h : d;
		return 19'(x) + 19'(m1) + 19'(m2);
	endfunction

endpackage

@@ hdl/range_encoder_interval.sv @@
// Multisymbol range encoder, interval stage: top level.
// Depends on rei_pkg (types, constants, frequency map and bit length helpers).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one coding interval per
//   transaction: cum_low, cum_high, total and prescale. Output channel
//   (out_valid / out_stall) carries 16-bit precarry words, each tagged with
//   last (final word of its interval) and bad_item (interval rejected).
//   A valid interval yields zero, one or two words; a rejected one yields a
//   single word 0 with last and bad_item set and leaves the coder untouched.
// Timing:
//   An accepted transaction is held in the input register, where
//   the whole low/range update (map, add, leading-zero count, renormalize)
//   runs in one pass and writes its words into a four-entry result buffer.
//   The first word reaches the output once it is written into that buffer.
//   One interval is taken per cycle as long as the buffer holds at most two
//   words; the output port drains one word per cycle while out_stall is
//   low, so a run of two-word intervals is paced by the output side.
// Reset clears the coder to low 0, range 0x8000, bit count -9 and empties
// the buffer. While the receiver stalls, words wait in the buffer and the
// input stalls once fewer than two free entries remain.
module range_encoder_interval #(
	parameter int WINDOW_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] cum_low,
	input  logic [15:0] cum_high,
	input  logic [15:0] total,
	input  logic        prescale,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] precarry_word,
	output logic        last,
	output logic        bad_item
);
	import rei_pkg::*;

	localparam int W = WINDOW_BITS;

	// input register
	logic        s1_valid_s1;
	logic [14:0] cum_low_s1;
	logic [15:0] cum_high_s1;
	logic [15:0] total_s1;
	logic        prescale_s1;

	// coder state
	logic [W-1:0]       coder_low_q;
	logic [15:0]        coder_range_q;
	logic signed [5:0]  bit_count_q;

	// result buffer
	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic exec;
	logic pop;
	logic bad_w;

	logic [3:0]  sc;
	logic [15:0] fl_p, fh_p, ft_p;
	logic        dbl;
	logic [16:0] fl_d, fh_d, ft_d;
	logic [16:0] d17;
	logic [15:0] d_w;
	logic [16:0] two_d;
	logic [16:0] g_w;
	logic [18:0] u_w, v_w, diff_w;
	logic [15:0] r_new;
	logic [W-1:0] low_sum;
	logic [4:0]  dsh;
	logic signed [5:0] s_sum;
	logic        emit, two;
	logic [3:0]  c_hi, c_lo;
	logic [W-1:0] mask_hi, mask_lo;
	logic [15:0] word_hi, word_lo;
	logic [W-1:0] low_kept;
	logic [W-1:0] low_next;
	logic [15:0] range_next;
	logic signed [5:0] count_next;

	res_t       entry0, entry1;
	logic [1:0] push_n;

	// --- handshakes --------------------------------------------------------
	// Execute the held interval only when at least two buffer entries are free.
	assign exec = s1_valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign in_stall = s1_valid_s1 && !exec;
	assign pop = out_valid && !out_stall;

	assign out_valid = (count_q != '0);
	assign precarry_word = fifo_q[rd_ptr_q].word;
	assign last = fifo_q[rd_ptr_q].last;
	assign bad_item = fifo_q[rd_ptr_q].bad;

	// --- validity ----------------------------------------------------------
	always_comb begin
		if (prescale_s1) begin
			bad_w = (total_s1 < PRE_MIN_TOTAL) || (total_s1 > Q15_TOTAL);
		end else begin
			bad_w = (total_s1 < MIN_TOTAL) || (total_s1 > Q15_TOTAL);
		end
		if (({1'b0, cum_low_s1} >= cum_high_s1) || (cum_high_s1 > total_s1)) begin
			bad_w = 1'b1;
		end
	end

	// --- interval mapping --------------------------------------------------
	always_comb begin
		// prescale: lift the total to 15 bits
		sc = 4'(5'd15 - bitlen16(total_s1 - 16'd1));
		if (prescale_s1) begin
			fl_p = {1'b0, cum_low_s1} << sc;
			fh_p = cum_high_s1 << sc;
			ft_p = total_s1 << sc;
		end else begin
			fl_p = {1'b0, cum_low_s1};
			fh_p = cum_high_s1;
			ft_p = total_s1;
		end

		// double the interval when the range holds twice the total
		dbl = {1'b0, coder_range_q} >= {ft_p, 1'b0};
		ft_d = dbl ? {ft_p, 1'b0} : {1'b0, ft_p};
		fl_d = dbl ? {fl_p, 1'b0} : {1'b0, fl_p};
		fh_d = dbl ? {fh_p, 1'b0} : {1'b0, fh_p};

		d17 = {1'b0, coder_range_q} - ft_d;
		d_w = d17[15:0];
		two_d = {d_w, 1'b0};
		g_w = (two_d > ft_d) ? (two_d - ft_d) : 17'd0;

		u_w = map_freq(fl_d, g_w, d_w);
		v_w = map_freq(fh_d, g_w, d_w);
		diff_w = v_w - u_w;
		r_new = diff_w[15:0];
		low_sum = coder_low_q + W'(u_w);
	end

	// --- renormalization ---------------------------------------------------
	always_comb begin
		dsh = 5'd16 - bitlen16(r_new);
		s_sum = bit_count_q + $signed({1'b0, dsh});
		emit = !s_sum[5];
		two = emit && (s_sum >= 6'sd8);

		// bit count sits in -9..-1, so adding 16 lands in 7..15
		c_hi = 4'(bit_count_q + 6'sd16);
		c_lo = c_hi - 4'd8;
		mask_hi = (W'(1) << c_hi) - W'(1);
		mask_lo = (W'(1) << c_lo) - W'(1);

		word_hi = 16'(low_sum >> c_hi);
		word_lo = 16'((low_sum & mask_hi) >> c_lo);

		if (!emit) begin
			low_kept = low_sum;
			count_next = s_sum;
		end else if (two) begin
			low_kept = low_sum & mask_lo;
			count_next = s_sum - 6'sd16;
		end else begin
			low_kept = low_sum & mask_hi;
			count_next = s_sum - 6'sd8;
		end

		low_next = low_kept << dsh;
		range_next = r_new << dsh;
	end

	// --- result words ------------------------------------------------------
	always_comb begin
		entry0 = '{word: word_hi, last: !two, bad: 1'b0};
		entry1 = '{word: word_lo, last: 1'b1, bad: 1'b0};
		push_n = 2'd0;
		if (bad_w) begin
			entry0 = '{word: '0, last: 1'b1, bad: 1'b1};
			push_n = 2'd1;
		end else if (two) begin
			push_n = 2'd2;
		end else if (emit) begin
			push_n = 2'd1;
		end
	end

	// --- registers ---------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	// payload of the input register: load on every accepted transaction
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cum_low_s1 <= cum_low;
			cum_high_s1 <= cum_high;
			total_s1 <= total;
			prescale_s1 <= prescale;
		end
	end

	// coder state: hold on a rejected interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coder_low_q <= '0;
			coder_range_q <= RANGE_RESET;
			bit_count_q <= COUNT_RESET;
		end else if (exec && !bad_w) begin
			coder_low_q <= low_next;
			coder_range_q <= range_next;
			bit_count_q <= count_next;
		end
	end

	// buffer entries
	always_ff @(posedge clk) begin
		if (exec && (push_n != 2'd0)) begin
			fifo_q[wr_ptr_q] <= entry0;
		end
		if (exec && (push_n == 2'd2)) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= entry1;
		end
	end

	// buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (exec) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (exec ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// --- assertions --------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result buffer overfilled");

	a_range_norm: assert property (@(posedge clk) disable iff (!arst_n)
		coder_range_q[15])
		else $error("range lost normalization");

	a_count_window: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_count_q <= -6'sd1) && (bit_count_q >= -6'sd9))
		else $error("bit count out of its window");

	a_bad_holds: assert property (@(posedge clk) disable iff (!arst_n)
		exec && bad_w |=> $stable(coder_low_q) && $stable(coder_range_q)
			&& $stable(bit_count_q))
		else $error("rejected interval changed coder state");

endmodule
